[rtl/slet_pkg.sv]
// shared constants, codes and controller/datapath command types
package slet_pkg;

   // line store and field limits
   localparam int LINE_CHARS  = 80;
   localparam int FIELD_LIMIT = 6;

   // derived widths
   localparam int CNT_W   = $clog2(LINE_CHARS + 1);
   localparam int ADDR_W  = $clog2(LINE_CHARS);
   localparam int FCNT_W  = $clog2(FIELD_LIMIT + 1);

   // fixed payload widths
   localparam int CHAR_W     = 8;
   localparam int KIND_W     = 2;
   localparam int POS_W      = 7;
   localparam int OUT_CNT_W  = 3;

   // backspace echo sequence
   localparam int BS_STEPS = 3;
   localparam int STEP_W   = 2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ECHO   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIELD  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_REJECT = 2'd3;

   // character codes
   localparam logic [CHAR_W-1:0] CH_BS      = 8'd8;
   localparam logic [CHAR_W-1:0] CH_LF      = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
   localparam logic [CHAR_W-1:0] CH_NUM_LO  = 8'd44;
   localparam logic [CHAR_W-1:0] CH_NUM_HI  = 8'd57;
   localparam logic [CHAR_W-1:0] CH_UPR_LO  = 8'd65;
   localparam logic [CHAR_W-1:0] CH_UPR_HI  = 8'd90;
   localparam logic [CHAR_W-1:0] CH_LWR_LO  = 8'd97;
   localparam logic [CHAR_W-1:0] CH_LWR_HI  = 8'd122;

   // output register source select
   typedef enum logic [2:0] {
      SEL_ECHO,
      SEL_BS,
      SEL_SPACE,
      SEL_REJECT,
      SEL_FIELD,
      SEL_END
   } out_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        take_byte;
      logic        store_char;
      logic        dec_count;
      logic        clr_count;
      logic        scan_start;
      logic        mem_read;
      logic        scan_eval;
      logic        step_clr;
      logic        step_inc;
      logic        out_load;
      out_sel_type out_sel;
      logic        out_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic byte_is_bs;
      logic byte_is_eol;
      logic byte_printable;
      logic count_zero;
      logic line_room;
      logic scan_more;
      logic emit_needed;
      logic out_free;
      logic step_mid;
      logic step_last;
   } status_type;

endpackage

[rtl/slet_ifs.sv]
// valid/ready channel interfaces for received bytes and result items

interface slet_req_if;
   logic                           valid;
   logic                           ready;
   logic [slet_pkg::CHAR_W-1:0]    rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slet_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [slet_pkg::KIND_W-1:0]       kind;
   logic [slet_pkg::CHAR_W-1:0]       echo_char;
   logic                              field_type;
   logic [slet_pkg::POS_W-1:0]        field_position;
   logic [slet_pkg::OUT_CNT_W-1:0]    field_count;
   logic                              last;

   modport source (output valid, output kind, output echo_char, output field_type,
                   output field_position, output field_count, output last,
                   input ready);
   modport sink   (input valid, input kind, input echo_char, input field_type,
                   input field_position, input field_count, input last,
                   output ready);
endinterface

[rtl/slet_dp.sv]
// datapath: byte register, line store, scan state and result register
module slet_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  slet_pkg::cmd_type           cmd,
   output slet_pkg::status_type        status,
   input  logic [slet_pkg::CHAR_W-1:0] rx_byte,
   slet_rsp_if.source                  rsp
);

   logic [slet_pkg::CHAR_W-1:0]    byte_ff, byte_in;
   logic [slet_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [slet_pkg::CNT_W-1:0]     ptr_ff, ptr_in;
   logic [slet_pkg::FCNT_W-1:0]    fields_ff, fields_in;
   logic                           run_valid_ff, run_valid_in;
   logic                           run_alpha_ff, run_alpha_in;
   logic [slet_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [slet_pkg::CHAR_W-1:0]    rd_data_ff;
   logic [slet_pkg::CHAR_W-1:0]    line_mem [slet_pkg::LINE_CHARS];

   logic                           out_valid_ff, out_valid_in;
   logic [slet_pkg::KIND_W-1:0]    kind_ff, kind_in;
   logic [slet_pkg::CHAR_W-1:0]    echo_ff, echo_in;
   logic                           ftype_ff, ftype_in;
   logic [slet_pkg::POS_W-1:0]     fpos_ff, fpos_in;
   logic [slet_pkg::OUT_CNT_W-1:0] fcnt_ff, fcnt_in;
   logic                           last_ff, last_in;

   logic                           cls_num, cls_alpha, cls_valid, run_differs, out_free;
   logic [slet_pkg::CNT_W-1:0]     chk_idx;

   // class of the character under scan
   assign cls_num   = (rd_data_ff >= slet_pkg::CH_NUM_LO) && (rd_data_ff <= slet_pkg::CH_NUM_HI);
   assign cls_alpha = ((rd_data_ff >= slet_pkg::CH_UPR_LO) && (rd_data_ff <= slet_pkg::CH_UPR_HI))
                   || ((rd_data_ff >= slet_pkg::CH_LWR_LO) && (rd_data_ff <= slet_pkg::CH_LWR_HI));
   assign cls_valid   = cls_num || cls_alpha;
   assign run_differs = !run_valid_ff || (run_alpha_ff != cls_alpha);
   assign chk_idx     = ptr_ff - 1'b1;
   assign out_free    = !out_valid_ff || rsp.ready;

   // status to the controller
   always_comb begin
      status.byte_is_bs     = (byte_ff == slet_pkg::CH_BS);
      status.byte_is_eol    = (byte_ff == slet_pkg::CH_CR) || (byte_ff == slet_pkg::CH_LF);
      status.byte_printable = (byte_ff >= slet_pkg::CH_SPACE);
      status.count_zero     = (count_ff == '0);
      status.line_room      = (count_ff < slet_pkg::CNT_W'(slet_pkg::LINE_CHARS));
      status.scan_more      = (ptr_ff < count_ff);
      status.emit_needed    = cls_valid && run_differs
                           && (fields_ff < slet_pkg::FCNT_W'(slet_pkg::FIELD_LIMIT));
      status.out_free       = out_free;
      status.step_mid       = (step_ff == slet_pkg::STEP_W'(1));
      status.step_last      = (step_ff == slet_pkg::STEP_W'(slet_pkg::BS_STEPS - 1));
   end

   // line editing and scan state
   always_comb begin
      byte_in      = byte_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      fields_in    = fields_ff;
      run_valid_in = run_valid_ff;
      run_alpha_in = run_alpha_ff;
      step_in      = step_ff;
      if (cmd.take_byte) begin
         byte_in = rx_byte;
      end
      if (cmd.store_char) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.dec_count) begin
         count_in = count_ff - 1'b1;
      end else if (cmd.clr_count) begin
         count_in = '0;
      end
      if (cmd.scan_start) begin
         ptr_in       = '0;
         fields_in    = '0;
         run_valid_in = 1'b0;
         run_alpha_in = 1'b0;
      end else begin
         if (cmd.mem_read) begin
            ptr_in = ptr_ff + 1'b1;
         end
         if (cmd.scan_eval) begin
            run_valid_in = cls_valid;
            run_alpha_in = cls_alpha;
            if (status.emit_needed) begin
               fields_in = fields_ff + 1'b1;
            end
         end
      end
      if (cmd.step_clr) begin
         step_in = '0;
      end else if (cmd.step_inc) begin
         step_in = step_ff + 1'b1;
      end
   end

   // result register contents
   always_comb begin
      out_valid_in = out_valid_ff;
      kind_in      = kind_ff;
      echo_in      = echo_ff;
      ftype_in     = ftype_ff;
      fpos_in      = fpos_ff;
      fcnt_in      = fcnt_ff;
      last_in      = last_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
         echo_in      = '0;
         ftype_in     = 1'b0;
         fpos_in      = '0;
         fcnt_in      = '0;
         last_in      = cmd.out_last;
         case (cmd.out_sel)
            slet_pkg::SEL_ECHO: begin
               kind_in = slet_pkg::KIND_ECHO;
               echo_in = byte_ff;
            end
            slet_pkg::SEL_BS: begin
               kind_in = slet_pkg::KIND_ECHO;
               echo_in = slet_pkg::CH_BS;
            end
            slet_pkg::SEL_SPACE: begin
               kind_in = slet_pkg::KIND_ECHO;
               echo_in = slet_pkg::CH_SPACE;
            end
            slet_pkg::SEL_FIELD: begin
               kind_in  = slet_pkg::KIND_FIELD;
               ftype_in = cls_alpha;
               fpos_in  = slet_pkg::POS_W'(chk_idx);
            end
            slet_pkg::SEL_END: begin
               kind_in = slet_pkg::KIND_END;
               fcnt_in = slet_pkg::OUT_CNT_W'(fields_ff);
            end
            default: begin
               kind_in = slet_pkg::KIND_REJECT;
            end
         endcase
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ptr_ff       <= '0;
         fields_ff    <= '0;
         run_valid_ff <= 1'b0;
         run_alpha_ff <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         fields_ff    <= fields_in;
         run_valid_ff <= run_valid_in;
         run_alpha_ff <= run_alpha_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      kind_ff  <= kind_in;
      echo_ff  <= echo_in;
      ftype_ff <= ftype_in;
      fpos_ff  <= fpos_in;
      fcnt_ff  <= fcnt_in;
      last_ff  <= last_in;
   end

   // line store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.store_char) begin
         line_mem[count_ff[slet_pkg::ADDR_W-1:0]] <= byte_ff;
      end
      if (cmd.mem_read) begin
         rd_data_ff <= line_mem[ptr_ff[slet_pkg::ADDR_W-1:0]];
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.kind           = kind_ff;
   assign rsp.echo_char      = echo_ff;
   assign rsp.field_type     = ftype_ff;
   assign rsp.field_position = fpos_ff;
   assign rsp.field_count    = fcnt_ff;
   assign rsp.last           = last_ff;

   // character count stays within the line store
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= slet_pkg::CNT_W'(slet_pkg::LINE_CHARS))
      else $error("character count beyond line store");

   // stores only go to a free entry
   a_store_room: assert property (@(posedge clock) disable iff (reset)
      cmd.store_char |-> status.line_room)
      else $error("store into a full line");

   // a line end leaves an empty line
   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_count |=> count_ff == '0)
      else $error("count not cleared after line end");

   // field count never passes the limit
   a_field_limit: assert property (@(posedge clock) disable iff (reset)
      fields_ff <= slet_pkg::FCNT_W'(slet_pkg::FIELD_LIMIT))
      else $error("field count beyond limit");

endmodule

[rtl/slet_ctrl.sv]
// controller: state machine sequencing edit, echo and line scan
module slet_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   slet_req_if.sink             req,
   input  slet_pkg::status_type status,
   output slet_pkg::cmd_type    cmd
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_DECODE  = 8'b0000_0010,
      S_BS      = 8'b0000_0100,
      S_ECHO    = 8'b0000_1000,
      S_REJECT  = 8'b0001_0000,
      S_SCAN_RD = 8'b0010_0000,
      S_SCAN    = 8'b0100_0000,
      S_END     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req.ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cmd.take_byte = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.byte_is_bs) begin
               if (status.count_zero) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.step_clr = 1'b1;
                  state_in     = S_BS;
               end
            end else if (status.byte_is_eol) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN_RD;
            end else if (status.byte_printable && status.line_room) begin
               cmd.store_char = 1'b1;
               state_in       = S_ECHO;
            end else begin
               state_in = S_REJECT;
            end
         end
         S_BS: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = status.step_mid ? slet_pkg::SEL_SPACE : slet_pkg::SEL_BS;
               cmd.out_last = status.step_last;
               if (status.step_last) begin
                  cmd.dec_count = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  cmd.step_inc = 1'b1;
               end
            end
         end
         S_ECHO: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = slet_pkg::SEL_ECHO;
               cmd.out_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_REJECT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = slet_pkg::SEL_REJECT;
               cmd.out_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SCAN_RD: begin
            if (status.scan_more) begin
               cmd.mem_read = 1'b1;
               state_in     = S_SCAN;
            end else begin
               state_in = S_END;
            end
         end
         S_SCAN: begin
            // hold while a field record waits for room in the result register
            if (!status.emit_needed || status.out_free) begin
               cmd.scan_eval = 1'b1;
               if (status.emit_needed) begin
                  cmd.out_load = 1'b1;
                  cmd.out_sel  = slet_pkg::SEL_FIELD;
               end
               if (status.scan_more) begin
                  cmd.mem_read = 1'b1;
               end else begin
                  state_in = S_END;
               end
            end
         end
         S_END: begin
            if (status.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_sel   = slet_pkg::SEL_END;
               cmd.out_last  = 1'b1;
               cmd.clr_count = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // an accepted byte is always decoded next
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> state_ff == S_DECODE)
      else $error("accepted item not decoded");

   // the result register is loaded only when it can take a result
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result register overwritten");

   // line store reads stay below the character count
   a_read_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_read |-> status.scan_more)
      else $error("read beyond stored characters");

endmodule

[rtl/serial_line_editor_tokenizer.sv]
// Echo or reject results pass through the decode state and then the echo or reject
// state into the result register. A new byte is taken only in the idle state, so
// each byte is finished before the next is accepted. A line end scans the stored
// characters, one entry per cycle via the single read port, except on result stalls.
// Reset: synchronous, clears the state machine, count and result register;
// the line store is not cleared and needs no clearing pass.
module serial_line_editor_tokenizer (
   input  logic        clock,
   input  logic        reset,
   slet_req_if.sink    req_chan,
   slet_rsp_if.source  rsp_chan
);

   slet_pkg::cmd_type    cmd;
   slet_pkg::status_type status;

   // sequencing
   slet_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .status (status),
      .cmd    (cmd)
   );

   // line store, scan and result register
   slet_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .status  (status),
      .rx_byte (req_chan.rx_byte),
      .rsp     (rsp_chan)
   );

endmodule
